[hw/rtl/h264nus_pkg.sv]
`default_nettype none

package h264nus_pkg;

  // Width of the length counter; header bits above it are ignored.
  localparam int LENGTH_BITS = 32;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_LENGTH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_UNIT   = 2'd3;

  // Separator modes.
  localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHORT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LONG   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd3;

  // Queue between the classifier and the result expander.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // The results of one input byte, in order: an optional end of unit,
  // up to three held zeros, an optional data byte and an optional tail.
  typedef struct packed {
    logic              pre_end;
    logic [1:0]        zeros;
    logic              has_data;
    logic [BYTE_W-1:0] data;
    logic              has_tail;
    logic [KIND_W-1:0] tail_kind;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // True while a run still has a result to deliver.
  function automatic logic run_busy(input run_t r);
    run_busy = r.pre_end | (r.zeros != 2'd0) | r.has_data | r.has_tail;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/h264nus_if.sv]
`default_nettype none

// Input channel: one message byte per beat.
interface h264nus_in_if import h264nus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

// Result channel: one result per beat.
interface h264nus_out_if import h264nus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_of_run;

  modport source (output valid, result_kind, payload_byte, last_of_run, input ready);
  modport sink   (input valid, result_kind, payload_byte, last_of_run, output ready);
endinterface

// Configuration channel: writes the separator mode.
interface h264nus_cfg_if import h264nus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] separator_mode;

  modport source (output valid, separator_mode, input ready);
  modport sink   (input valid, separator_mode, output ready);
endinterface

`default_nettype wire

[hw/rtl/h264nus_front.sv]
`default_nettype none

module h264nus_front import h264nus_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_message,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_mode,
  input  queue_stat_t       q_stat,
  output logic              q_push,
  output run_t              q_run
);

  logic [MODE_W-1:0]      mode_r;
  logic [1:0]             phase_r, phase_nxt;
  logic                   open_r, open_nxt;
  logic [1:0]             hdr_r, hdr_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                   body_r, body_nxt;

  logic                   accept;
  logic                   want_short, want_long;
  logic                   is_zero, is_one;
  logic                   match, hold;
  logic [1:0]             hold_phase;
  logic [LENGTH_BITS-1:0] len;
  run_t                   run;

  assign in_ready   = !q_stat.full;
  assign accept     = in_valid && in_ready;
  assign want_short = mode_r[0];
  assign want_long  = mode_r[1];
  assign is_zero    = (in_data_byte == 8'h00);
  assign is_one     = (in_data_byte == 8'h01);
  assign len        = {acc_r[LENGTH_BITS-BYTE_W-1:0], in_data_byte};

  // Start code tracking: a candidate continues, completes or fails.
  always_comb begin
    match      = 1'b0;
    hold       = 1'b0;
    hold_phase = 2'd0;
    case (phase_r)
      2'd0: begin
        hold       = is_zero;
        hold_phase = 2'd1;
      end
      2'd1: begin
        hold       = is_zero;
        hold_phase = 2'd2;
      end
      2'd2: begin
        hold       = is_zero && want_long;
        hold_phase = 2'd3;
        match      = is_one && want_short;
      end
      default: begin
        match = is_one && want_long;
      end
    endcase
  end

  // Classify the byte into a run of results and the next state.
  always_comb begin
    run       = '0;
    phase_nxt = phase_r;
    open_nxt  = open_r;
    hdr_nxt   = hdr_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    body_nxt  = body_r;

    if (mode_r == MODE_LENGTH) begin
      if (body_r) begin
        run.has_data = 1'b1;
        run.data     = in_data_byte;
        rem_nxt      = rem_r - LENGTH_BITS'(1);
        if (rem_r == LENGTH_BITS'(1)) begin
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_END;
          body_nxt      = 1'b0;
        end else if (in_end_of_message) begin
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_BAD_UNIT;
        end
      end else if (hdr_r == 2'd3) begin
        // Last header byte: the length is complete.
        hdr_nxt = 2'd0;
        acc_nxt = '0;
        if (len == '0) begin
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_END;
        end else begin
          body_nxt = 1'b1;
          rem_nxt  = len;
          if (in_end_of_message) begin
            run.has_tail  = 1'b1;
            run.tail_kind = KIND_BAD_UNIT;
          end
        end
      end else begin
        hdr_nxt = hdr_r + 2'd1;
        acc_nxt = len;
        if (in_end_of_message) begin
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_BAD_LENGTH;
        end
      end
    end else begin
      if (match) begin
        run.pre_end = open_r;
        open_nxt    = 1'b1;
        phase_nxt   = 2'd0;
        if (in_end_of_message) begin
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_END;
        end
      end else if (hold) begin
        phase_nxt = hold_phase;
        if (in_end_of_message && open_r) begin
          run.zeros     = hold_phase;
          run.has_tail  = 1'b1;
          run.tail_kind = KIND_END;
        end
      end else begin
        // The candidate fails: held zeros and this byte are data if a unit is open.
        phase_nxt = 2'd0;
        if (open_r) begin
          run.zeros    = phase_r;
          run.has_data = 1'b1;
          run.data     = in_data_byte;
          if (in_end_of_message) begin
            run.has_tail  = 1'b1;
            run.tail_kind = KIND_END;
          end
        end
      end
    end
  end

  assign q_push = accept && run_busy(run);
  assign q_run  = run;

  // Splitter state; the end of a message and a mode write both clear the parse state; a mode write also loads the mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BOTH;
      phase_r <= 2'd0;
      open_r  <= 1'b0;
      hdr_r   <= 2'd0;
      acc_r   <= '0;
      rem_r   <= '0;
      body_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r  <= cfg_mode;
      phase_r <= 2'd0;
      open_r  <= 1'b0;
      hdr_r   <= 2'd0;
      acc_r   <= '0;
      rem_r   <= '0;
      body_r  <= 1'b0;
    end else if (accept) begin
      if (in_end_of_message) begin
        phase_r <= 2'd0;
        open_r  <= 1'b0;
        hdr_r   <= 2'd0;
        acc_r   <= '0;
        rem_r   <= '0;
        body_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        open_r  <= open_nxt;
        hdr_r   <= hdr_nxt;
        acc_r   <= acc_nxt;
        rem_r   <= rem_nxt;
        body_r  <= body_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/h264nus_queue.sv]
`default_nettype none

module h264nus_queue import h264nus_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  run_t        push_run,
  input  logic        pop,
  output run_t        head_run,
  output queue_stat_t stat
);

  run_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_run   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_run;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/h264nus_back.sv]
`default_nettype none

module h264nus_back import h264nus_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  run_t              head_run,
  input  queue_stat_t       q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_result_kind,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic              out_last_of_run
);

  run_t              cur_r, cur_nxt;
  logic              cur_vld_r, cur_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;

  run_t              src;
  logic              src_vld;
  logic              fire;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] pbyte;

  assign src     = cur_vld_r ? cur_r : head_run;
  assign src_vld = cur_vld_r || !q_stat.empty;
  assign fire    = src_vld && (!out_vld_r || out_ready);
  assign q_pop   = fire && !cur_vld_r;

  // Take the next result off the front of the run.
  always_comb begin
    cur_nxt = src;
    kind    = KIND_DATA;
    pbyte   = '0;
    if (src.pre_end) begin
      kind            = KIND_END;
      cur_nxt.pre_end = 1'b0;
    end else if (src.zeros != 2'd0) begin
      cur_nxt.zeros = src.zeros - 2'd1;
    end else if (src.has_data) begin
      pbyte            = src.data;
      cur_nxt.has_data = 1'b0;
    end else begin
      kind             = src.tail_kind;
      cur_nxt.has_tail = 1'b0;
    end
  end

  assign cur_vld_nxt = fire ? run_busy(cur_nxt) : cur_vld_r;
  assign out_vld_nxt = fire || (out_vld_r && !out_ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Remaining run and the output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      cur_r  <= cur_nxt;
      kind_r <= kind;
      byte_r <= pbyte;
      last_r <= !run_busy(cur_nxt);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_kind  = kind_r;
  assign out_payload_byte = byte_r;
  assign out_last_of_run  = last_r;

endmodule

`default_nettype wire

[hw/rtl/h264_nal_unit_splitter_core.sv]
`default_nettype none

// Channel   Dir  Beat carries
// in_bus    in   data_byte, end_of_message
// out_bus   out  result_kind, payload_byte, last_of_run
// cfg_bus   in   separator_mode (always ready)
//
// A byte is taken every cycle while the four-entry run queue has room; each
// byte yields zero to five results, which pass through a run queue slot and
// the output register and leave at one result per cycle while out_bus is ready.
// Reset is synchronous; it sets the mode to both start codes and empties
// the queue. An output stall backs up the queue, then stalls the input.

module h264_nal_unit_splitter_core import h264nus_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  h264nus_in_if.sink        in_bus,
  h264nus_out_if.source     out_bus,
  h264nus_cfg_if.sink       cfg_bus
);

  queue_stat_t q_stat;
  logic        q_push;
  logic        q_pop;
  run_t        q_run;
  run_t        head_run;
  logic        cfg_we;

  assign cfg_bus.ready = 1'b1;
  assign cfg_we        = cfg_bus.valid;

  // Classifier and splitter state.
  h264nus_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_bus.valid),
    .in_ready          (in_bus.ready),
    .in_data_byte      (in_bus.data_byte),
    .in_end_of_message (in_bus.end_of_message),
    .cfg_we            (cfg_we),
    .cfg_mode          (cfg_bus.separator_mode),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_run             (q_run)
  );

  // Run queue.
  h264nus_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (q_run),
    .pop      (q_pop),
    .head_run (head_run),
    .stat     (q_stat)
  );

  // Result expander and output register.
  h264nus_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_run         (head_run),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_bus.valid),
    .out_ready        (out_bus.ready),
    .out_result_kind  (out_bus.result_kind),
    .out_payload_byte (out_bus.payload_byte),
    .out_last_of_run  (out_bus.last_of_run)
  );

`ifndef SYNTHESIS
  // A run is never written into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("run pushed into a full queue");

  // The expander never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("run popped from an empty queue");

  // Only data beats carry a byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.result_kind != KIND_DATA) |-> out_bus.payload_byte == 8'h00)
    else $error("non-data result carries a payload byte");

  // Reset leaves the queue empty and the output idle.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (q_stat.empty && !out_bus.valid))
    else $error("queue or output busy after reset");
`endif

endmodule

`default_nettype wire
